FILE: hw/rtl/mopq_pkg.sv
// ----------------------------------------------------------------------------
// mopq_pkg
// Shared types and constants of the Morton-order priority queue.
// ----------------------------------------------------------------------------
package mopq_pkg;

    localparam int COORD_W  = 32;
    localparam int CFG_W    = 12;
    localparam int STATUS_W = 2;
    localparam int AGE_W    = 32;
    localparam int SCALE_MUL = 50000;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } kind_t;

endpackage

FILE: hw/rtl/mopq_if.sv
// ----------------------------------------------------------------------------
// mopq_in_if / mopq_out_if
// Valid/ready channels of the queue: request items in, result items out.
// ----------------------------------------------------------------------------
interface mopq_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    modport source (output valid, kind, coord_0, coord_1, coord_2, input ready);
    modport sink   (input valid, kind, coord_0, coord_1, coord_2, output ready);
endinterface

interface mopq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_coord_0;
    logic [31:0] out_coord_1;
    logic [31:0] out_coord_2;
    modport source (output valid, status, out_coord_0, out_coord_1, out_coord_2,
                    input ready);
    modport sink   (input valid, status, out_coord_0, out_coord_1, out_coord_2,
                    output ready);
endinterface

FILE: hw/rtl/mopq_ram.sv
// ----------------------------------------------------------------------------
// mopq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mopq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/mopq_keygen.sv
// ----------------------------------------------------------------------------
// mopq_keygen
// Scales coordinates (two registered stages) and interleaves them into a key.
// ----------------------------------------------------------------------------
module mopq_keygen
    import mopq_pkg::*;
#(
    parameter int SCALED_BITS = 64
) (
    input  logic                       clk,
    input  logic [CFG_W-1:0]           range_offset,
    input  logic [COORD_W-1:0]         coord [3],
    output logic [3*SCALED_BITS-1:0]   key
);
    localparam int SUM_W  = 44;
    localparam int PROD_W = SUM_W + 16;
    localparam logic [PROD_W-1:0] LIM = PROD_W'({SCALED_BITS{1'b1}});

    logic signed [SUM_W-1:0] sum_reg [3];
    logic [PROD_W-1:0]       scaled_reg [3];
    logic [SCALED_BITS-1:0]  sat [3];

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 3; d++)
        begin
            sum_reg[d] <= {{(SUM_W-28){range_offset[CFG_W-1]}}, range_offset, 16'd0}
                        + {{(SUM_W-COORD_W){coord[d][COORD_W-1]}}, coord[d]};
            if (sum_reg[d] <= 0)
            begin
                scaled_reg[d] <= '0;
            end
            else
            begin
                scaled_reg[d] <= (PROD_W'(sum_reg[d]) * PROD_W'(SCALE_MUL)) >> 16;
            end
        end
    end

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            sat[d] = (scaled_reg[d] > LIM) ? '1 : SCALED_BITS'(scaled_reg[d]);
        end
        for (int b = 0; b < SCALED_BITS; b++)
        begin
            for (int d = 0; d < 3; d++)
            begin
                key[3*b + (2-d)] = sat[d][b];
            end
        end
    end
endmodule

FILE: hw/rtl/morton_order_priority_queue_core.sv
// ----------------------------------------------------------------------------
// morton_order_priority_queue_core
// Priority queue of 3-D points ordered by their Morton (Z-order) key.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink): kind 0 inserts coord_0..2 (Q16.16), kind 1 pops the entry
//        with the largest key; ties go to the earliest inserted entry.
//   rsp  (source): one item per request: status and, on a pop, the point.
//   cfg_we/cfg_wdata write range_offset; write only while idle.
// Operation:
//   Insert: two scale stages, key build with RAM write, output load.
//   Pop: the scan reads one entry per cycle out of the entry RAM (key, age
//   and coords in one word, one read port), so the scan length sets the rate.
//   Empty pop and full insert are answered from idle, with no worked states.
// One item is in work at a time; req.ready is high only when the block is idle
// and the output register is empty or its result leaves in that cycle.
// A stalled receiver holds the result register; no new item is taken until
// the result leaves.
// Reset: queue empty, insert stamp 0, range_offset 2. RAMs are not cleared;
// only entries below occupancy are ever used.
// ----------------------------------------------------------------------------
module morton_order_priority_queue_core
    import mopq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int SCALED_BITS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    mopq_in_if.sink          req,
    mopq_out_if.source       rsp
);
    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W = 3 * SCALED_BITS;
    localparam int ENT_W = KEY_W + AGE_W + 3 * COORD_W;

    typedef enum logic [2:0] {S_IDLE, S_INS, S_SCAN, S_MOVE, S_OUT} state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   range_offset_reg;
    logic [CW-1:0]      occ_reg;
    logic [AGE_W-1:0]   counter_reg;
    logic [1:0]         ins_cnt_reg;
    logic [CW-1:0]      rd_idx_reg;   // next address presented to the RAM
    logic [CW-1:0]      cmp_idx_reg;  // index of entry on RAM read data
    logic               cmp_valid_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [ENT_W-1:0]   best_reg;
    logic [COORD_W-1:0] coord_reg [3];
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [COORD_W-1:0] out_c_reg [3];

    // entry RAM
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [ENT_W-1:0]   wdata, rdata;
    logic [KEY_W-1:0]   key;

    mopq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    mopq_keygen #(.SCALED_BITS(SCALED_BITS)) u_keygen (
        .clk(clk), .range_offset(range_offset_reg), .coord(coord_reg), .key(key)
    );

    // entry layout: {key, age, c0, c1, c2}
    logic [KEY_W-1:0] rkey, bkey;
    logic [AGE_W-1:0] rage, bage;
    logic             rd_beats;
    assign rkey = rdata[ENT_W-1 -: KEY_W];
    assign bkey = best_reg[ENT_W-1 -: KEY_W];
    assign rage = rdata[3*COORD_W +: AGE_W];
    assign bage = best_reg[3*COORD_W +: AGE_W];
    assign rd_beats = (rkey > bkey) ||
                      ((rkey == bkey) && ((counter_reg - rage) > (counter_reg - bage)));

    logic out_free;
    logic out_set;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;

    // result register loads: end of a worked item, or an immediate answer
    assign out_set = ((state_reg == S_OUT) && out_free) ||
                     ((state_reg == S_IDLE) && req.valid && req.ready &&
                      ((req.kind == KIND_INSERT) ? (occ_reg == CW'(QUEUE_DEPTH))
                                                 : (occ_reg == '0)));

    always_comb
    begin
        we    = 1'b0;
        waddr = occ_reg[AW-1:0];
        wdata = {key, counter_reg, coord_reg[0], coord_reg[1], coord_reg[2]};
        // entry 0 is on the address while idle, so a scan starts with it on rdata
        raddr = (state_reg == S_IDLE) ? '0 : rd_idx_reg[AW-1:0];
        if (state_reg == S_INS && ins_cnt_reg == 2'd2)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_MOVE && cmp_valid_reg &&
                 cmp_idx_reg[AW-1:0] != best_idx_reg)
        begin
            // last entry (now on read data) fills the freed slot
            we    = 1'b1;
            waddr = best_idx_reg;
            wdata = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            range_offset_reg <= CFG_W'(2);
            occ_reg          <= '0;
            counter_reg      <= '0;
            ins_cnt_reg      <= '0;
            rd_idx_reg       <= '0;
            cmp_idx_reg      <= '0;
            cmp_valid_reg    <= 1'b0;
            best_idx_reg     <= '0;
            best_reg         <= '0;
            coord_reg        <= '{default: '0};
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_INSERTED;
            out_c_reg        <= '{default: '0};
        end
        else
        begin
            if (cfg_we)
            begin
                range_offset_reg <= cfg_wdata;
            end
            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        coord_reg[0] <= req.coord_0;
                        coord_reg[1] <= req.coord_1;
                        coord_reg[2] <= req.coord_2;
                        out_c_reg[0] <= '0;
                        out_c_reg[1] <= '0;
                        out_c_reg[2] <= '0;
                        if (req.kind == KIND_INSERT)
                        begin
                            if (occ_reg == CW'(QUEUE_DEPTH))
                            begin
                                out_status_reg <= ST_FULL;
                            end
                            else
                            begin
                                ins_cnt_reg <= '0;
                                state_reg   <= S_INS;
                            end
                        end
                        else if (occ_reg == '0)
                        begin
                            out_status_reg <= ST_EMPTY;
                        end
                        else
                        begin
                            rd_idx_reg    <= CW'(1);
                            cmp_idx_reg   <= '0;
                            cmp_valid_reg <= 1'b1;
                            best_idx_reg  <= '0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_INS:
                begin
                    ins_cnt_reg <= ins_cnt_reg + 2'd1;
                    if (ins_cnt_reg == 2'd2)
                    begin
                        occ_reg        <= occ_reg + CW'(1);
                        counter_reg    <= counter_reg + AGE_W'(1);
                        out_status_reg <= ST_INSERTED;
                        state_reg      <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    // rdata holds entry cmp_idx_reg
                    if (cmp_valid_reg)
                    begin
                        if (cmp_idx_reg == '0 || rd_beats)
                        begin
                            best_reg     <= rdata;
                            best_idx_reg <= cmp_idx_reg[AW-1:0];
                        end
                    end
                    if (rd_idx_reg == occ_reg)
                    begin
                        // scan done; re-read last entry for the move
                        cmp_valid_reg <= 1'b0;
                        rd_idx_reg    <= occ_reg - CW'(1);
                        cmp_idx_reg   <= occ_reg - CW'(1);
                        state_reg     <= S_MOVE;
                    end
                    else
                    begin
                        cmp_idx_reg <= rd_idx_reg;
                        rd_idx_reg  <= rd_idx_reg + CW'(1);
                    end
                end
                S_MOVE:
                begin
                    // while cmp_valid_reg is low, wait for the last entry on rdata;
                    // once it is set, write it into the freed slot
                    if (!cmp_valid_reg)
                    begin
                        cmp_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        occ_reg        <= occ_reg - CW'(1);
                        out_status_reg <= ST_POPPED;
                        out_c_reg[0]   <= best_reg[2*COORD_W +: COORD_W];
                        out_c_reg[1]   <= best_reg[COORD_W +: COORD_W];
                        out_c_reg[2]   <= best_reg[0 +: COORD_W];
                        state_reg      <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_coord_0 = out_c_reg[0];
    assign rsp.out_coord_1 = out_c_reg[1];
    assign rsp.out_coord_2 = out_c_reg[2];

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("occupancy above depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("accept while busy");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (occ_reg != '0))
        else $error("scan of empty store");
    a_popped_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE && cmp_valid_reg) |=> (occ_reg == $past(occ_reg) - CW'(1)))
        else $error("pop did not shrink store");
`endif
endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the Morton-order priority queue: a clocked driver
// feeds insert and pop items from a queue, a clocked monitor checks every
// result against a behavioral queue model kept in the bench.
// ----------------------------------------------------------------------------
module tb
    import mopq_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int CYC_LIMIT    = 1500000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
    } req_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
    } rsp_item_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    mopq_in_if  req_ch ();
    mopq_out_if rsp_ch ();

    morton_order_priority_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Queue model: keys are 192-bit interleaved scaled coordinates.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] mdl_offset;
    logic [191:0]     mdl_key   [DEPTH];
    logic [95:0]      mdl_point [DEPTH];
    logic [31:0]      mdl_stamp [DEPTH];
    logic [31:0]      mdl_inserts;
    int               mdl_count;

    function automatic logic [63:0] scaled_of(logic [31:0] coord);
        logic signed [63:0] sum;
        logic [127:0]       prod;
        sum = 64'($signed(mdl_offset)) * 65536 + 64'($signed(coord));
        if (sum <= 0)
            return '0;
        prod = 128'(sum) * 128'(SCALE_MUL);
        prod = prod >> 16;
        if (prod[127:64] != 0)
            return '1;
        return prod[63:0];
    endfunction

    function automatic logic [191:0] morton_key(logic [31:0] a, logic [31:0] b,
                                                 logic [31:0] c);
        logic [63:0]  s [3];
        logic [191:0] k;
        s[0] = scaled_of(a);
        s[1] = scaled_of(b);
        s[2] = scaled_of(c);
        for (int bit_i = 63; bit_i >= 0; bit_i--)
            for (int d = 0; d < 3; d++)
                k[3 * bit_i + 2 - d] = s[d][bit_i];
        return k;
    endfunction

    // Applies one accepted request to the model, returns its result item.
    function automatic rsp_item_t queue_apply(req_item_t it);
        rsp_item_t r;
        int        best;
        r = '{status: ST_INSERTED, c0: '0, c1: '0, c2: '0};
        if (it.kind == KIND_INSERT) begin
            if (mdl_count >= DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            mdl_key[mdl_count]   = morton_key(it.c0, it.c1, it.c2);
            mdl_point[mdl_count] = {it.c0, it.c1, it.c2};
            mdl_stamp[mdl_count] = mdl_inserts;
            mdl_inserts++;
            mdl_count++;
            return r;
        end
        if (mdl_count == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        best = 0;
        for (int i = 1; i < mdl_count; i++)
            if (mdl_key[i] > mdl_key[best] ||
                (mdl_key[i] == mdl_key[best] &&
                 32'(mdl_inserts - mdl_stamp[i]) > 32'(mdl_inserts - mdl_stamp[best])))
                best = i;
        r.status = ST_POPPED;
        {r.c0, r.c1, r.c2} = mdl_point[best];
        // last entry fills the hole
        mdl_key[best]   = mdl_key[mdl_count - 1];
        mdl_point[best] = mdl_point[mdl_count - 1];
        mdl_stamp[best] = mdl_stamp[mdl_count - 1];
        mdl_count--;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------
    req_item_t pending_reqs [$];
    rsp_item_t expected_rsps [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_trigger = 1'b0; // starts the long receiver stall
    int        hold_off = 0;        // long receiver stall, counted down below
    int        errors = 0;
    int        n_offered = 0;
    int        n_accepted = 0;
    int        n_pops = 0;
    int        n_full = 0;
    int        n_empty = 0;
    longint    cycles = 0;

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.kind = 1'b0;
        req_ch.coord_0 = '0;
        req_ch.coord_1 = '0;
        req_ch.coord_2 = '0;
        rsp_ch.ready = 1'b0;
    end

    // Inputs move on the falling edge so the rising edge sees them settled.
    // The offered item is done once the monitor has counted its acceptance.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!req_ch.valid || n_accepted == n_offered) begin
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    req_ch.valid   <= 1'b1;
                    req_ch.kind    <= pending_reqs[0].kind;
                    req_ch.coord_0 <= pending_reqs[0].c0;
                    req_ch.coord_1 <= pending_reqs[0].c1;
                    req_ch.coord_2 <= pending_reqs[0].c2;
                    n_offered      <= n_offered + 1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random idling plus one long stall counted here.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (hold_trigger) begin
                hold_off     <= STALL_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off     <= hold_off - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_item_t got;
        rsp_item_t exp_r;
        cycles <= cycles + 1;
        if (req_ch.valid && req_ch.ready) begin
            void'(pending_reqs.pop_front());
            expected_rsps.insert(expected_rsps.size(),
                                 queue_apply({kind_t'(req_ch.kind), req_ch.coord_0,
                                              req_ch.coord_1, req_ch.coord_2}));
            n_accepted <= n_accepted + 1;
        end
        if (rsp_ch.valid && rsp_ch.ready) begin
            got = {status_t'(rsp_ch.status), rsp_ch.out_coord_0,
                   rsp_ch.out_coord_1, rsp_ch.out_coord_2};
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors <= errors + 1;
            end else begin
                exp_r = expected_rsps.pop_front();
                if (got.status == ST_POPPED)
                    n_pops <= n_pops + 1;
                if (got.status == ST_FULL)
                    n_full <= n_full + 1;
                if (got.status == ST_EMPTY)
                    n_empty <= n_empty + 1;
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             exp_r.status, got.status);
                    errors <= errors + 1;
                end
                if (got.c0 !== exp_r.c0 || got.c1 !== exp_r.c1 || got.c2 !== exp_r.c2) begin
                    $display("%0t: point expected %h %h %h got %h %h %h", $time,
                             exp_r.c0, exp_r.c1, exp_r.c2, got.c0, got.c1, got.c2);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        if (cycles > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_req(kind_t k, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        req_item_t it;
        it = '{kind: k, c0: a, c1: b, c2: c};
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5, 0))
            0: return $urandom;
            1: return 32'($signed($urandom_range(200000, 0)) - 100000);
            2: return $urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return {16'($urandom_range(40, 0)) - 16'd20, 16'($urandom)};
            default: return 32'($urandom_range(4, 0)) << 16;   // coarse: ties likely
        endcase
    endfunction

    task automatic wait_drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_offset(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mdl_offset = v;
    endtask

    // Fill and drain bursts with random content: favors deep queue states.
    task automatic random_phase(int n_items);
        int left;
        int burst;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(70, 1);
            for (int i = 0; i < burst && left > 0; i++, left--)
                if ($urandom_range(99, 0) < 55 + (burst % 2) * 20)
                    push_req(KIND_INSERT, rand_coord(), rand_coord(), rand_coord());
                else
                    push_req(KIND_POP, $urandom, $urandom, $urandom);
            while (pending_reqs.size() > 8)
                @(posedge clk);
        end
    endtask

    initial
    begin
        mdl_offset  = 12'd2;
        mdl_inserts = '0;
        mdl_count   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pop, field extremes, equal keys, full store.
        push_req(KIND_POP, '1, '1, '1);
        push_req(KIND_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_req(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_req(KIND_INSERT, '0, '0, '0);
        push_req(KIND_INSERT, 32'hfffe_0000, '0, 32'h0001_0000);
        push_req(KIND_INSERT, 32'h0001_0000, '0, 32'hfffe_0000);
        push_req(KIND_INSERT, 32'h0000_0005, 32'h0000_0007, 32'h0000_0009);
        push_req(KIND_INSERT, 32'h0000_0005, 32'h0000_0007, 32'h0000_0009);
        for (int i = 0; i < 8; i++)
            push_req(KIND_POP, '0, '0, '0);
        for (int i = 0; i < DEPTH + 2; i++)
            push_req(KIND_INSERT, rand_coord(), rand_coord(), rand_coord());
        // Long receiver stall, with inserts refused by the full store and four pops.
        for (int i = 0; i < 4; i++)
            push_req(KIND_POP, '0, '0, '0);
        @(posedge clk);
        hold_trigger = 1'b1;
        @(posedge clk);
        hold_trigger = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 52;
        wait_drain();

        // Extreme offsets; the store still holds entries keyed at the old one,
        // which is fine since keys are built at insert time.
        write_offset(12'h400);
        random_phase(250);
        wait_drain();
        write_offset(12'hc00);
        send_idle_pct = 52;
        recv_idle_pct = 31;
        random_phase(250);
        wait_drain();
        write_offset(12'h000);
        random_phase(150);
        wait_drain();
        write_offset(12'h7ff);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(150);
        wait_drain();
        write_offset(12'h002);
        random_phase(250);
        wait_drain();

        $display("items %0d: %0d pops returned a point, %0d empty pops, %0d refused inserts",
                 n_accepted, n_pops, n_empty, n_full);
        $display("range_offset swept over -1024, 0, 2, 1024 and 2047 with idling and stalls");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
